FILE: hdl/grid_line_of_sight_unit_defines.svh
// Assertion macros shared by the grid line-of-sight unit RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/glos_pkg.sv
// Package for the grid line-of-sight unit: map geometry, stream field layout,
// controller state type and the command/status structs. No dependencies.
package glos_pkg;

    // Map geometry and tile size.
    localparam int MAP_COLS    = 32;
    localparam int MAP_ROWS    = 32;
    localparam int TILE_PIXELS = 32;

    localparam int PIX_W     = 10;
    localparam int CELL_W    = 5;
    localparam int TILE_W    = $clog2(((1 << PIX_W) - 1) / TILE_PIXELS + 1);
    localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int ERR_W     = TILE_W + 3;

    // Input tdata layout, lowest bit first.
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + CELL_W;
    localparam int WALK_BIT  = ROW_LSB + CELL_W;
    localparam int SX_LSB    = WALK_BIT + 1;
    localparam int SY_LSB    = SX_LSB + PIX_W;
    localparam int TX_LSB    = SY_LSB + PIX_W;
    localparam int TY_LSB    = TX_LSB + PIX_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    // Request kinds carried on tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DELIVER
    } glos_state_t;

    typedef struct packed {
        logic clear_step;
        logic write_cell;
        logic load;
        logic setup;
        logic step;
        logic set_result;
        logic result_val;
        logic publish;
    } glos_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic endpoint_bad;
        logic cell_open;
        logic at_target;
        logic out_busy;
    } glos_status_t;

endpackage

FILE: hdl/glos_datapath.sv
// Datapath of the grid line-of-sight unit: tile map memory, Bresenham stepper
// registers and the result register. Depends on glos_pkg.
module glos_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [glos_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  glos_pkg::glos_cmd_t              cmd,
    output glos_pkg::glos_status_t           status,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [glos_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import glos_pkg::*;

    function automatic logic [ADDR_W-1:0] map_addr(input int col, input int row);
        map_addr = ADDR_W'(row * MAP_COLS + col);
    endfunction

    logic                     map_mem [MAP_DEPTH];
    logic                     rd_data_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        clr_addr_reg;

    logic [TILE_W-1:0]        cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic [TILE_W-1:0]        dx_reg, dy_reg;
    logic                     sx_neg_reg, sy_neg_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     res_reg;
    logic                     out_valid_reg;
    logic                     out_data_reg;

    logic [CELL_W-1:0]        wr_col, wr_row;
    logic                     wr_in_map;
    logic [TILE_W-1:0]        dx_calc, dy_calc;
    logic signed [ERR_W-1:0]  dx_s, dy_s, e2, err_next;
    logic                     step_x, step_y;
    logic [TILE_W-1:0]        next_x, next_y;

    assign wr_col    = s_axis_tdata[COL_LSB +: CELL_W];
    assign wr_row    = s_axis_tdata[ROW_LSB +: CELL_W];
    assign wr_in_map = (int'(wr_col) < MAP_COLS) && (int'(wr_row) < MAP_ROWS);

    // Set-up arithmetic on the latched tiles.
    assign dx_calc = (tgt_x_reg >= cur_x_reg) ? (tgt_x_reg - cur_x_reg)
                                              : (cur_x_reg - tgt_x_reg);
    assign dy_calc = (tgt_y_reg >= cur_y_reg) ? (tgt_y_reg - cur_y_reg)
                                              : (cur_y_reg - tgt_y_reg);

    // One Bresenham step.
    assign dx_s     = $signed(ERR_W'(dx_reg));
    assign dy_s     = $signed(ERR_W'(dy_reg));
    assign e2       = err_reg <<< 1;
    assign step_x   = e2 > -dy_s;
    assign step_y   = e2 < dx_s;
    assign err_next = err_reg - (step_x ? dy_s : ERR_W'(0)) + (step_y ? dx_s : ERR_W'(0));
    assign next_x   = !step_x ? cur_x_reg
                              : (sx_neg_reg ? cur_x_reg - TILE_W'(1) : cur_x_reg + TILE_W'(1));
    assign next_y   = !step_y ? cur_y_reg
                              : (sy_neg_reg ? cur_y_reg - TILE_W'(1) : cur_y_reg + TILE_W'(1));

    // While stepping, fetch the next cell so that it is ready in the next cycle.
    assign rd_addr = cmd.step ? map_addr(int'(next_x), int'(next_y))
                              : map_addr(int'(cur_x_reg), int'(cur_y_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            map_mem[clr_addr_reg] <= 1'b0;
        end
        else if (cmd.write_cell && wr_in_map)
        begin
            map_mem[map_addr(int'(wr_col), int'(wr_row))] <= s_axis_tdata[WALK_BIT];
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= TILE_W'(s_axis_tdata[SX_LSB +: PIX_W] / TILE_PIXELS);
            cur_y_reg <= TILE_W'(s_axis_tdata[SY_LSB +: PIX_W] / TILE_PIXELS);
            tgt_x_reg <= TILE_W'(s_axis_tdata[TX_LSB +: PIX_W] / TILE_PIXELS);
            tgt_y_reg <= TILE_W'(s_axis_tdata[TY_LSB +: PIX_W] / TILE_PIXELS);
        end
        else if (cmd.step)
        begin
            cur_x_reg <= next_x;
            cur_y_reg <= next_y;
        end
        if (cmd.setup)
        begin
            dx_reg     <= dx_calc;
            dy_reg     <= dy_calc;
            sx_neg_reg <= !(cur_x_reg < tgt_x_reg);
            sy_neg_reg <= !(cur_y_reg < tgt_y_reg);
            err_reg    <= $signed(ERR_W'(dx_calc)) - $signed(ERR_W'(dy_calc));
        end
        else if (cmd.step)
        begin
            err_reg <= err_next;
        end
        if (cmd.set_result)
        begin
            res_reg <= cmd.result_val;
        end
        if (cmd.publish)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign status.clear_last   = clr_addr_reg == ADDR_W'(MAP_DEPTH - 1);
    assign status.endpoint_bad = (int'(cur_x_reg) >= MAP_COLS) || (int'(cur_y_reg) >= MAP_ROWS)
                              || (int'(tgt_x_reg) >= MAP_COLS) || (int'(tgt_y_reg) >= MAP_ROWS);
    assign status.cell_open    = rd_data_reg;
    assign status.at_target    = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign status.out_busy     = out_valid_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_data_reg};

endmodule

FILE: hdl/glos_ctrl.sv
// Controller of the grid line-of-sight unit: map clearing pass, request
// decode, walk sequencing and result hand-off. Depends on glos_pkg and the defines header.
`include "grid_line_of_sight_unit_defines.svh"

module glos_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   req_type,
    output logic                   in_ready,
    output glos_pkg::glos_cmd_t    cmd,
    input  glos_pkg::glos_status_t status
);
    import glos_pkg::*;

    glos_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        cmd.write_cell = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                if (status.endpoint_bad)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b0;
                    state_next     = ST_DELIVER;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!status.cell_open)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b0;
                    state_next     = ST_DELIVER;
                end
                else if (status.at_target)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b1;
                    state_next     = ST_DELIVER;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DELIVER:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    `GLOS_ASSERT_NOW(a_step_only_off_target, cmd.step, status.cell_open && !status.at_target, "walk stepped from a blocked cell or from the target")
    `GLOS_ASSERT_NOW(a_publish_into_free_slot, cmd.publish, !status.out_busy, "result published over an untaken result")
    `GLOS_ASSERT_NEXT(a_clear_pass_ends_idle, cmd.clear_step && status.clear_last, state_reg == ST_IDLE && in_ready, "clearing pass did not hand over to idle")

endmodule

FILE: hdl/grid_line_of_sight_unit.sv
// Top level of the grid line-of-sight unit: stream ports, controller and datapath.
// Depends on glos_pkg, glos_ctrl and glos_datapath.
//
// The unit keeps a 32 x 32 tile map, one bit per cell (1 walkable, 0 wall), and
// answers line-of-sight queries over it. After reset the map is swept to all
// blocked, one cell per cycle; s_axis_tready stays low during the sweep. A
// transfer with tuser low writes one map cell (writes outside the map are
// dropped) and produces no result. A transfer with tuser high carries start
// and target pixel positions; each is divided by the tile size of 32 pixels,
// and the cells between the two tiles are walked with a Bresenham error-term
// stepper, both ends included. The map memory has one registered read port
// and the walk reads one cell per cycle, up to and including the first
// blocked cell (at most max(dx, dy) + 1 cells); a query with an endpoint off
// the map returns blocked without a walk. One result transfer follows each
// query, with path_clear in bit 0 of m_axis_tdata. The result waits in an
// output register, so the next request is accepted while an earlier result
// is still unclaimed.
module grid_line_of_sight_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, lowest bit first: cell_col[4:0], cell_row[9:5], cell_walkable[10],
    // start_x[20:11], start_y[30:21], target_x[40:31], target_y[50:41], zeros.
    input  logic [glos_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type (0 write a map cell, 1 line-of-sight query).
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata, lowest bit first: path_clear[0], zeros.
    output logic [glos_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import glos_pkg::*;

    glos_cmd_t    cmd;
    glos_status_t status;

    // The controller sequences every request; the datapath holds the map,
    // the stepper and the result register.
    glos_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .req_type      (s_axis_tuser),
        .in_ready      (s_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    glos_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
